FILE: design/tql_pkg.sv
// Shared types, constants and helpers of the tabular Q-learning agent.
`timescale 1ns / 1ps

package tql_pkg;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE   = 8'd0,
    CFG_DISCOUNT     = 8'd1,
    CFG_EXPLORE_RATE = 8'd2,
    CFG_TRAIN_MODE   = 8'd3
  } cfg_idx_e;

  // Register reset values
  localparam logic [15:0] LEARN_RATE_RST   = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST     = 16'd58982;
  localparam logic [15:0] EXPLORE_RATE_RST = 16'd6554;
  localparam logic        TRAIN_MODE_RST   = 1'b1;

  // Velocity classes per position row
  localparam int unsigned VCLASSES = 3;
  localparam logic [1:0]  VC_FLOOR = 2'd0;
  localparam logic [1:0]  VC_RISE  = 2'd1;
  localparam logic [1:0]  VC_FALL  = 2'd2;

  // Random generator
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [2:0]  JUMP_MASK = 3'h7;

  // Value arithmetic, Q16.16
  localparam int unsigned VAL_W = 32;

  typedef struct packed {
    logic [15:0] learn_rate;
    logic [15:0] discount;
    logic [15:0] explore_rate;
    logic        train_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MUL_G,
    ST_TD,
    ST_MUL_A,
    ST_WRITE,
    ST_PICK
  } state_e;

  // One right shift of the Fibonacci LFSR, taps x^16+x^14+x^13+x^11
  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[15:1]};
  endfunction

endpackage

FILE: design/tql_if.sv
// Channel interfaces of the agent: observations, actions and register writes.
`timescale 1ns / 1ps

interface tql_obs_if;
  logic               valid;
  logic               ready;
  logic [7:0]         position;
  logic               on_floor;
  logic               moving_up;
  logic signed [31:0] reward;
  logic               episode_start;

  modport source (output valid, position, on_floor, moving_up, reward, episode_start,
                  input ready);
  modport sink   (input valid, position, on_floor, moving_up, reward, episode_start,
                  output ready);
endinterface

interface tql_act_if;
  logic valid;
  logic ready;
  logic action;
  logic was_random;

  modport source (output valid, action, was_random, input ready);
  modport sink   (input valid, action, was_random, output ready);
endinterface

interface tql_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tql_pkg::CFG_IDX_W-1:0]  index;
  logic [tql_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/tql_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tql_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1536,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tql_cfg_regs.sv
// Configuration register file of the agent.
`timescale 1ns / 1ps

module tql_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  tql_cfg_if.sink       cfg_i,
  output tql_pkg::cfg_t cfg_o
);
  import tql_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid && cfg_i.ready;

  // Decode the register index, drop unknown ones
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (cfg_i.index)
        CFG_LEARN_RATE:   cfg_d.learn_rate   = cfg_i.data;
        CFG_DISCOUNT:     cfg_d.discount     = cfg_i.data;
        CFG_EXPLORE_RATE: cfg_d.explore_rate = cfg_i.data;
        CFG_TRAIN_MODE:   cfg_d.train_mode   = cfg_i.data[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_rate   <= LEARN_RATE_RST;
      cfg_q.discount     <= DISCOUNT_RST;
      cfg_q.explore_rate <= EXPLORE_RATE_RST;
      cfg_q.train_mode   <= TRAIN_MODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/tql_agent_ctrl.sv
// Sequencer and datapath: row scan, value update, action choice and output register.
`timescale 1ns / 1ps

module tql_agent_ctrl #(
  parameter int unsigned POSITIONS = 256,
  parameter int unsigned ACTIONS   = 2,
  localparam int unsigned DEPTH = POSITIONS * tql_pkg::VCLASSES * ACTIONS,
  localparam int unsigned DAW   = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tql_pkg::cfg_t               cfg_i,
  tql_obs_if.sink                     obs_i,
  tql_act_if.source                   act_o,
  output logic                        mem_we_o,
  output logic [DAW-1:0]              mem_waddr_o,
  output logic [tql_pkg::VAL_W-1:0]   mem_wdata_o,
  output logic [DAW-1:0]              mem_raddr_o,
  input  logic [tql_pkg::VAL_W-1:0]   mem_rdata_i
);
  import tql_pkg::*;

  localparam int unsigned ROWS = POSITIONS * VCLASSES;
  localparam int unsigned SW   = $clog2(ROWS);
  localparam int unsigned AW   = $clog2(ACTIONS);
  localparam int unsigned CW   = $clog2(ACTIONS + 2);

  // Control state
  state_e          state_q, state_d;
  logic [DAW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [CW-1:0]   iss_cnt_q, iss_cnt_d;
  logic            rd_vld_q, rd_vld_d;
  logic            upd_q, upd_d;
  logic            rescan_q, rescan_d;
  logic [SW-1:0]   last_state_q, last_state_d;
  logic [AW-1:0]   last_act_q, last_act_d;
  logic [15:0]     lfsr_q, lfsr_d;
  logic            out_vld_q, out_vld_d;

  // Datapath registers
  logic [SW-1:0]        now_q;
  logic signed [31:0]   reward_q;
  logic [CW-1:0]        rd_idx_q;
  logic signed [31:0]   max_q;
  logic [AW-1:0]        arg_q;
  logic signed [31:0]   qv_q;
  logic signed [48:0]   prod_g_q;
  logic signed [34:0]   td_q;
  logic signed [51:0]   prod_a_q;
  logic                 out_act_q;
  logic                 out_rnd_q;

  // Combinational helpers
  logic               accept;
  logic               out_free;
  logic [1:0]         vclass;
  logic [SW-1:0]      pos_c;
  logic [SW-1:0]      now_d;
  logic [CW-1:0]      iss_last;
  logic               iss_en;
  logic               scan_done;
  logic [DAW-1:0]     prev_slot;
  logic signed [31:0] rdata_s;
  logic signed [32:0] gm;
  logic signed [34:0] td_d;
  logic signed [35:0] delta;
  logic signed [36:0] nv;
  logic signed [31:0] nv_sat;
  logic [15:0]        lfsr1, lfsr2;
  logic               rnd;
  logic [AW-1:0]      act_full;

  assign accept   = obs_i.valid && obs_i.ready;
  assign out_free = !out_vld_q || act_o.ready;
  assign rdata_s  = $signed(mem_rdata_i);

  // Form the state index of the observation, clamp the position
  always_comb begin
    if (obs_i.on_floor) begin
      vclass = VC_FLOOR;
    end else if (obs_i.moving_up) begin
      vclass = VC_RISE;
    end else begin
      vclass = VC_FALL;
    end
    if (32'(obs_i.position) >= POSITIONS) begin
      pos_c = SW'(POSITIONS - 1);
    end else begin
      pos_c = SW'(obs_i.position);
    end
    now_d = SW'(32'(pos_c) * VCLASSES + 32'(vclass));
  end

  // Row reads first, then the previous slot on the first pass
  assign iss_last  = rescan_q ? CW'(ACTIONS - 1) : CW'(ACTIONS);
  assign iss_en    = (state_q == ST_SCAN) && (iss_cnt_q <= iss_last);
  assign scan_done = rd_vld_q && (rd_idx_q == iss_last);
  assign prev_slot = DAW'(32'(last_state_q) * ACTIONS + 32'(last_act_q));

  always_comb begin
    if (iss_cnt_q == CW'(ACTIONS)) begin
      mem_raddr_o = prev_slot;
    end else begin
      mem_raddr_o = DAW'(32'(now_q) * ACTIONS + 32'(iss_cnt_q));
    end
  end

  // Update arithmetic: round-half-up scaling by 2^-16, saturate the sum
  always_comb begin
    gm    = 33'((prod_g_q + 49'sd32768) >>> 16);
    td_d  = 35'(reward_q) + 35'(gm) - 35'(qv_q);
    delta = 36'((prod_a_q + 52'sd32768) >>> 16);
    nv    = 37'(qv_q) + 37'(delta);
    if (nv[36:31] == 6'b000000 || nv[36:31] == 6'b111111) begin
      nv_sat = nv[31:0];
    end else if (nv[36]) begin
      nv_sat = 32'sh8000_0000;
    end else begin
      nv_sat = 32'sh7fff_ffff;
    end
  end

  // Exploration draw
  always_comb begin
    lfsr1 = lfsr_step(lfsr_q);
    lfsr2 = lfsr_step(lfsr1);
    rnd   = cfg_i.train_mode && (lfsr1 < cfg_i.explore_rate);
    if (rnd) begin
      act_full = AW'((lfsr2[2:0] & JUMP_MASK) == 3'b000);
    end else begin
      act_full = arg_q;
    end
  end

  // Next state and outputs
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    iss_cnt_d    = iss_cnt_q;
    rd_vld_d     = iss_en;
    upd_d        = upd_q;
    rescan_d     = rescan_q;
    last_state_d = last_state_q;
    last_act_d   = last_act_q;
    lfsr_d       = lfsr_q;
    out_vld_d    = out_vld_q && !act_o.ready;
    obs_i.ready  = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = prev_slot;
    mem_wdata_o  = nv_sat;

    if (iss_en) begin
      iss_cnt_d = iss_cnt_q + CW'(1);
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_cnt_q;
        mem_wdata_o = '0;
        clr_cnt_d   = clr_cnt_q + DAW'(1);
        if (clr_cnt_q == DAW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        obs_i.ready = 1'b1;
        if (obs_i.valid) begin
          upd_d     = cfg_i.train_mode && !obs_i.episode_start;
          rescan_d  = 1'b0;
          iss_cnt_d = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (!rescan_q && upd_q) begin
            state_d = ST_MUL_G;
          end else begin
            state_d = ST_PICK;
          end
        end
      end
      ST_MUL_G: state_d = ST_TD;
      ST_TD:    state_d = ST_MUL_A;
      ST_MUL_A: state_d = ST_WRITE;
      ST_WRITE: begin
        mem_we_o = 1'b1;
        // Rescan the row when the written entry lies in it
        if (last_state_q == now_q) begin
          rescan_d  = 1'b1;
          iss_cnt_d = '0;
          state_d   = ST_SCAN;
        end else begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          last_state_d = now_q;
          last_act_d   = act_full;
          if (cfg_i.train_mode) begin
            lfsr_d = rnd ? lfsr2 : lfsr1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      iss_cnt_q    <= '0;
      rd_vld_q     <= 1'b0;
      upd_q        <= 1'b0;
      rescan_q     <= 1'b0;
      last_state_q <= '0;
      last_act_q   <= '0;
      lfsr_q       <= LFSR_SEED;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      iss_cnt_q    <= iss_cnt_d;
      rd_vld_q     <= rd_vld_d;
      upd_q        <= upd_d;
      rescan_q     <= rescan_d;
      last_state_q <= last_state_d;
      last_act_q   <= last_act_d;
      lfsr_q       <= lfsr_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // Datapath: capture the item, track row max, run the multiplies, register the action
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q    <= now_d;
      reward_q <= obs_i.reward;
    end
    rd_idx_q <= iss_cnt_q;
    if (rd_vld_q) begin
      if (rd_idx_q == CW'(ACTIONS)) begin
        qv_q <= rdata_s;
      end else if (rd_idx_q == '0 || rdata_s > max_q) begin
        max_q <= rdata_s;
        arg_q <= rd_idx_q[AW-1:0];
      end
    end
    if (state_q == ST_MUL_G) begin
      prod_g_q <= $signed({1'b0, cfg_i.discount}) * max_q;
    end
    if (state_q == ST_TD) begin
      td_q <= td_d;
    end
    if (state_q == ST_MUL_A) begin
      prod_a_q <= $signed({1'b0, cfg_i.learn_rate}) * td_q;
    end
    if (state_q == ST_PICK && out_free) begin
      out_act_q <= act_full[0];
      out_rnd_q <= rnd;
    end
  end

  assign act_o.valid      = out_vld_q;
  assign act_o.action     = out_act_q;
  assign act_o.was_random = out_rnd_q;

endmodule

FILE: design/tabular_q_learning_agent.sv
// Each accepted item runs a row scan, then with a table update the MUL_G, TD, MUL_A and
// WRITE states, with a rescan when the updated entry lies in the current row, then PICK.
// A new item is taken only in IDLE, after PICK has registered the last action; the single
// value memory port and the row scan (one entry per cycle) bound the item rate, and a
// stalled action channel holds PICK. Reset: registers take their reset values, then a
// clearing pass zeroes all POSITIONS*3*ACTIONS entries; no item is accepted until it ends.
`timescale 1ns / 1ps

module tabular_q_learning_agent #(
  parameter int unsigned POSITIONS = 256,
  parameter int unsigned ACTIONS   = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tql_cfg_if.sink   cfg_i,
  tql_obs_if.sink   obs_i,
  tql_act_if.source act_o
);
  import tql_pkg::*;

  localparam int unsigned DEPTH = POSITIONS * VCLASSES * ACTIONS;
  localparam int unsigned DAW   = $clog2(DEPTH);

  cfg_t             cfg;
  logic             mem_we;
  logic [DAW-1:0]   mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [DAW-1:0]   mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  // Register file
  tql_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Value table
  tql_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer and datapath
  tql_agent_ctrl #(
    .POSITIONS (POSITIONS),
    .ACTIONS   (ACTIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .obs_i       (obs_i),
    .act_o       (act_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

FILE: tb/tabular_q_learning_agent_test.sv
// Self-checking testbench of the tabular Q-learning agent: random play with a bit-exact predictor.
`timescale 1ns / 1ps

module tabular_q_learning_agent_test;
  import tql_pkg::*;

  localparam int unsigned POSITIONS   = 256;
  localparam int unsigned ACTIONS     = 2;
  localparam int unsigned ROWS        = POSITIONS * VCLASSES;
  localparam int unsigned IDLE_LIMIT  = 8000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE_WAIT = 4 * (2 * ACTIONS + 8);
  localparam int unsigned PHASE_ITEMS = 150;
  localparam longint      VAL_MAX     = 64'sd2147483647;
  localparam longint      VAL_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic [7:0]         position;
    logic               on_floor;
    logic               moving_up;
    logic signed [31:0] reward;
    logic               episode_start;
  } obs_item_t;

  typedef struct packed {
    logic action;
    logic was_random;
  } act_item_t;

  typedef enum int {
    STALL_NONE,
    STALL_SHORT,
    STALL_LONG
  } stall_mode_e;

  logic clk;
  logic rst_n;

  tql_cfg_if cfg_bus ();
  tql_obs_if obs_bus ();
  tql_act_if act_bus ();

  tabular_q_learning_agent #(
    .POSITIONS(POSITIONS),
    .ACTIONS  (ACTIONS)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .obs_i (obs_bus),
    .act_o (act_bus)
  );

  // Predictor state: table, previous step, random generator and registers
  logic signed [31:0] q_table [ROWS*ACTIONS];
  int unsigned        prev_row;
  int unsigned        prev_act;
  logic [15:0]        explore_lfsr;
  cfg_t               agent_cfg;

  obs_item_t   obs_backlog [$];
  act_item_t   actions_due [$];
  obs_item_t   next_obs;
  obs_item_t   seen_obs;
  act_item_t   due_act;
  int          obs_unsent;
  int          mismatches;
  int unsigned idle_cycles;
  logic        obs_taken;
  logic        cfg_taken;

  int unsigned burst_left;
  int unsigned gap_left;

  stall_mode_e stall_mode;
  int unsigned mode_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_req;
  bit          hold_done;

  // Round a Q16.16 product to nearest, halves toward plus infinity
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [15:0] lfsr_advance(input logic [15:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[15:1]};
  endfunction

  // Greedy choice in a row, lowest index wins ties
  function automatic int unsigned row_argmax(input int unsigned row);
    int unsigned best;
    best = 0;
    for (int unsigned a = 1; a < ACTIONS; a++) begin
      if (q_table[row*ACTIONS + a] > q_table[row*ACTIONS + best]) best = a;
    end
    return best;
  endfunction

  // Update the table for the previous step, then choose the next action
  function automatic act_item_t predict_action(input obs_item_t o);
    int unsigned pos;
    int unsigned row;
    int unsigned slot;
    logic [1:0]  vclass;
    longint      q;
    longint      best_next;
    longint      td;
    longint      nv;
    act_item_t   res;
    pos = o.position;
    if (pos >= POSITIONS) pos = POSITIONS - 1;
    vclass = o.on_floor ? VC_FLOOR : (o.moving_up ? VC_RISE : VC_FALL);
    row = pos * VCLASSES + vclass;

    if (agent_cfg.train_mode && !o.episode_start) begin
      slot      = prev_row * ACTIONS + prev_act;
      q         = longint'(q_table[slot]);
      best_next = longint'(q_table[row*ACTIONS + row_argmax(row)]);
      td = longint'($signed(o.reward)) + round_q16(longint'(agent_cfg.discount) * best_next) - q;
      nv = q + round_q16(longint'(agent_cfg.learn_rate) * td);
      if (nv > VAL_MAX) nv = VAL_MAX;
      else if (nv < VAL_MIN) nv = VAL_MIN;
      q_table[slot] = nv[31:0];
    end

    res.action     = 1'b0;
    res.was_random = 1'b0;
    if (agent_cfg.train_mode) begin
      explore_lfsr = lfsr_advance(explore_lfsr);
      if (explore_lfsr < agent_cfg.explore_rate) begin
        res.was_random = 1'b1;
        explore_lfsr   = lfsr_advance(explore_lfsr);
        res.action     = ((explore_lfsr[2:0] & JUMP_MASK) == 3'd0);
      end
    end
    if (!res.was_random) res.action = 1'(row_argmax(row));

    prev_row = row;
    prev_act = res.action;
    return res;
  endfunction

  function automatic obs_item_t obs_item(input logic [7:0] position, input logic on_floor,
                                         input logic moving_up, input logic signed [31:0] reward,
                                         input logic episode_start);
    obs_item_t it;
    it.position      = position;
    it.on_floor      = on_floor;
    it.moving_up     = moving_up;
    it.reward        = reward;
    it.episode_start = episode_start;
    return it;
  endfunction

  task automatic queue_obs(input obs_item_t it);
    obs_backlog.push_back(it);
    obs_unsent++;
  endtask

  // Queue mostly episodes of play with random content, some noise items
  task automatic queue_play(input int count);
    obs_item_t it;
    int        left;
    int        run;
    int        pos;
    int        step;
    int        style;
    bit        fixed_pos;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 15) begin
        it = obs_item(8'($urandom), 1'($urandom), 1'($urandom), 32'($urandom), 1'($urandom));
        queue_obs(it);
        left--;
      end else begin
        run       = int'($urandom_range(2, 30));
        pos       = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                                : int'($urandom_range(0, 7));
        fixed_pos = ($urandom_range(0, 2) == 0);
        style     = int'($urandom_range(0, 9));
        for (step = 0; step < run && left > 0; step++) begin
          if (!fixed_pos) begin
            pos = pos + int'($urandom_range(0, 2)) - 1;
            if (pos < 0) pos = 0;
            if (pos > 255) pos = 255;
          end
          it.position  = 8'(pos);
          it.on_floor  = 1'($urandom);
          it.moving_up = 1'($urandom);
          // a broken episode now and then lacks its start mark
          it.episode_start = (step == 0) && ($urandom_range(0, 9) != 0);
          if (style < 6) it.reward = 32'(int'($urandom_range(0, 262144)) - 131072);
          else if (style < 8) it.reward = 32'($urandom);
          else if (style == 8) it.reward = {16'h7FFF, 16'($urandom)};
          else it.reward = {16'h8000, 16'($urandom)};
          queue_obs(it);
          left--;
        end
      end
    end
  endtask

  // Wait until every queued item has been taken and answered
  task automatic wait_drained();
    do @(negedge clk); while (obs_unsent != 0 || actions_due.size() != 0);
  endtask

  // Called at a falling edge; leaves valid high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(negedge clk); while (!cfg_taken);
  endtask

  task automatic set_regs(input logic [15:0] lr, input logic [15:0] dc, input logic [15:0] er,
                          input logic tm);
    write_reg(CFG_LEARN_RATE, lr);
    write_reg(CFG_DISCOUNT, dc);
    write_reg(CFG_EXPLORE_RATE, er);
    write_reg(CFG_TRAIN_MODE, {15'd0, tm});
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive observation items in bursts with random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (obs_bus.valid && !obs_taken) begin
        // hold the offered item until taken
      end else if (gap_left != 0) begin
        obs_bus.valid <= 1'b0;
        gap_left--;
      end else if (obs_backlog.size() != 0) begin
        next_obs = obs_backlog.pop_front();
        obs_bus.position      <= next_obs.position;
        obs_bus.on_floor      <= next_obs.on_floor;
        obs_bus.moving_up     <= next_obs.moving_up;
        obs_bus.reward        <= next_obs.reward;
        obs_bus.episode_start <= next_obs.episode_start;
        obs_bus.valid         <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
        end
      end else begin
        obs_bus.valid <= 1'b0;
      end
    end
  end

  // Stall the action channel on a pattern of its own, plus one long hold-off
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      act_bus.ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      act_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      act_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      act_bus.ready <= 1'b1;
      case (stall_mode)
        STALL_SHORT: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
        STALL_LONG:  if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
        default: ;
      endcase
    end
  end

  // Sample handshakes, predict on each taken item, check each action
  always @(posedge clk) begin
    obs_taken <= obs_bus.valid && obs_bus.ready;
    cfg_taken <= cfg_bus.valid && cfg_bus.ready;
    if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        CFG_LEARN_RATE:   agent_cfg.learn_rate   = cfg_bus.data;
        CFG_DISCOUNT:     agent_cfg.discount     = cfg_bus.data;
        CFG_EXPLORE_RATE: agent_cfg.explore_rate = cfg_bus.data;
        CFG_TRAIN_MODE:   agent_cfg.train_mode   = cfg_bus.data[0];
        default: ;
      endcase
    end
    if (obs_bus.valid && obs_bus.ready) begin
      seen_obs.position      = obs_bus.position;
      seen_obs.on_floor      = obs_bus.on_floor;
      seen_obs.moving_up     = obs_bus.moving_up;
      seen_obs.reward        = obs_bus.reward;
      seen_obs.episode_start = obs_bus.episode_start;
      actions_due.push_back(predict_action(seen_obs));
      obs_unsent--;
    end
    if (act_bus.valid && act_bus.ready) begin
      if (actions_due.size() == 0) begin
        $error("action item arrived with none due: action %0d was_random %0d",
               act_bus.action, act_bus.was_random);
        mismatches++;
      end else begin
        due_act = actions_due.pop_front();
        if (act_bus.action !== due_act.action) begin
          $error("action: expected %0d, actual %0d", due_act.action, act_bus.action);
          mismatches++;
        end
        if (act_bus.was_random !== due_act.was_random) begin
          $error("was_random: expected %0d, actual %0d", due_act.was_random, act_bus.was_random);
          mismatches++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((obs_bus.valid && obs_bus.ready) || (act_bus.valid && act_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int unsigned k = 0; k < ROWS*ACTIONS; k++) q_table[k] = '0;
    prev_row               = 0;
    prev_act               = 0;
    explore_lfsr           = LFSR_SEED;
    agent_cfg.learn_rate   = LEARN_RATE_RST;
    agent_cfg.discount     = DISCOUNT_RST;
    agent_cfg.explore_rate = EXPLORE_RATE_RST;
    agent_cfg.train_mode   = TRAIN_MODE_RST;
    obs_unsent  = 0;
    mismatches  = 0;
    idle_cycles = 0;
    obs_taken   = 1'b0;
    cfg_taken   = 1'b0;
    burst_left  = 0;
    gap_left    = 0;
    stall_mode  = STALL_NONE;
    mode_left   = 0;
    stall_left  = 0;
    hold_left   = 0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;

    obs_bus.valid         = 1'b0;
    obs_bus.position      = '0;
    obs_bus.on_floor      = 1'b0;
    obs_bus.moving_up     = 1'b0;
    obs_bus.reward        = '0;
    obs_bus.episode_start = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    act_bus.ready         = 1'b0;

    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every velocity class, ties and same-row updates
    queue_obs(obs_item(8'd0, 1'b1, 1'b0, 32'sd0, 1'b1));
    queue_obs(obs_item(8'd0, 1'b1, 1'b0, 32'sh7FFFFFFF, 1'b0));
    queue_obs(obs_item(8'd0, 1'b1, 1'b0, 32'sh7FFFFFFF, 1'b0));
    queue_obs(obs_item(8'd255, 1'b0, 1'b1, 32'sh80000000, 1'b0));
    queue_obs(obs_item(8'd255, 1'b0, 1'b0, -32'sd1, 1'b0));
    queue_obs(obs_item(8'd255, 1'b1, 1'b1, 32'sd1, 1'b0));
    queue_obs(obs_item(8'd128, 1'b0, 1'b0, 32'sh00010000, 1'b0));
    queue_obs(obs_item(8'd0, 1'b0, 1'b1, 32'sh7FFFFFFF, 1'b1));
    for (int k = 0; k < 14; k++) begin
      queue_obs(obs_item(8'(k % 2), 1'(k / 2), 1'b0,
                         (k % 3 == 0) ? -32'sh20000 : 32'sh18000, 1'b0));
    end
    wait_drained();

    // Full-strength learning drives entries into saturation; receiver holds off once
    set_regs(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
    hold_req = 1'b1;
    queue_play(PHASE_ITEMS);
    wait_drained();

    // No learning, nearly always exploring
    set_regs(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    queue_play(PHASE_ITEMS);
    wait_drained();

    // Greedy only, table frozen
    set_regs(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    queue_play(PHASE_ITEMS);
    wait_drained();

    // A write to an index beyond the register list must change nothing
    write_reg(8'($urandom_range(CFG_TRAIN_MODE + 1, 255)), 16'($urandom));
    set_regs(16'($urandom), 16'($urandom), 16'h8000, 1'b1);
    queue_play(PHASE_ITEMS);
    wait_drained();

    for (int k = 0; k < 2; k++) begin
      set_regs(pick_rate(), pick_rate(), pick_rate(), ($urandom_range(0, 3) != 0));
      queue_play(PHASE_ITEMS);
      wait_drained();
    end

    set_regs(LEARN_RATE_RST, DISCOUNT_RST, EXPLORE_RATE_RST, TRAIN_MODE_RST);
    queue_play(PHASE_ITEMS);
    wait_drained();

    // Let any stray action item show up before the verdict
    repeat (SETTLE_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tql_pkg.sv
design/tql_if.sv
design/tql_ram.sv
design/tql_cfg_regs.sv
design/tql_agent_ctrl.sv
design/tabular_q_learning_agent.sv
tb/tabular_q_learning_agent_test.sv
